// ===== rtl/cle_pkg.sv =====
// Package for the circular list engine: command and status codes, default sizes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package cle_pkg;

	localparam int LIST_DEPTH_DEF  = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_READ_ALL   = 3'd0,
		CMD_INS_FRONT  = 3'd1,
		CMD_INS_BACK   = 3'd2,
		CMD_INS_AFTER  = 3'd3,
		CMD_DEL_FRONT  = 3'd4,
		CMD_DEL_BACK   = 3'd5,
		CMD_DEL_KEY    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RA_HOLD = 3'd0,
		RA_HEAD = 3'd1,
		RA_FREE = 3'd2,
		RA_TAIL = 3'd3,
		RA_LINK = 3'd4
	} rsel_t;

	typedef struct packed {
		logic    latch;
		rsel_t   rsel;
		logic    walk_init;
		logic    minus2;
		logic    step;
		logic    to_tail;
		logic    head_del;
		logic    found;
		logic    ins;
		logic    add;
		logic    add2;
		logic    drop;
		logic    dfree;
		logic    set_res;
		status_t res;
		logic    emit_res;
		logic    emit_walk;
	} cle_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       empty;
		logic       full;
		logic       one;
		logic       match;
		logic       rem_zero;
		logic       out_free;
	} cle_sts_t;

endpackage

// ===== rtl/cle_if.sv =====
// Handshake channels of the circular list engine: command channel and result channel.
// No dependencies.
`timescale 1ns / 1ps
interface cle_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic signed [31:0] item_value;
	logic signed [31:0] match_key;
	modport source (output valid, cmd, item_value, match_key, input ready);
	modport sink (input valid, cmd, item_value, match_key, output ready);
endinterface

interface cle_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [31:0] entry_value;
	logic              last;
	logic [5:0]        entry_count;
	modport source (output valid, status, entry_value, last, entry_count, input ready);
	modport sink (input valid, status, entry_value, last, entry_count, output ready);
endinterface

// ===== rtl/circular_list_engine.sv =====
// Top level of the circular list engine: controller plus datapath.
// Depends on cle_pkg, cle_if, cle_ctrl and cle_dpath.
//
//   channel    dir  payload                                       transfer when
//   cmd_chan   in   cmd, item_value, match_key                    valid && ready
//   res_chan   out  status, entry_value, last, entry_count        valid && ready
//
// One command at a time. Unknown codes and empty or full refusals go from decode to the result;
// insert front/back passes through the insert state, front delete through drop and free; read-all
// walks the entries; keyed commands and back delete walk the links, one store read per cycle.
// Reset is asynchronous; the free chain comes out of reset through per-slot link valid flags.
// A stalled result channel holds the engine in place, including in the middle of a read-all.
`timescale 1ns / 1ps
module circular_list_engine #(
	parameter int LIST_DEPTH  = cle_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_WIDTH = cle_pkg::VALUE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cle_in_if.sink    cmd_chan,
	cle_out_if.source res_chan
);
	import cle_pkg::*;

	cle_cmd_t ctl;
	cle_sts_t sts;

	cle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_chan.valid),
		.in_ready (cmd_chan.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cle_dpath #(.LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_cmd   (cmd_chan.cmd),
		.in_item  (cmd_chan.item_value),
		.in_key   (cmd_chan.match_key),
		.res_chan (res_chan),
		.ctl      (ctl),
		.sts      (sts)
	);
endmodule

// ===== rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cle_ctrl.sv =====
// Controller state machine of the circular list engine.
// Depends on cle_pkg; drives the datapath through cle_cmd_t and reads cle_sts_t.
`timescale 1ns / 1ps
module cle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cle_pkg::cle_sts_t sts,
	output cle_pkg::cle_cmd_t ctl
);
	import cle_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DECODE = 11'b000_0000_0010,
		S_RWALK  = 11'b000_0000_0100,
		S_INS    = 11'b000_0000_1000,
		S_SRCH   = 11'b000_0001_0000,
		S_BWALK  = 11'b000_0010_0000,
		S_ADD    = 11'b000_0100_0000,
		S_ADD2   = 11'b000_1000_0000,
		S_DROP   = 11'b001_0000_0000,
		S_DFREE  = 11'b010_0000_0000,
		S_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.rsel = RA_HOLD;
		ctl.res  = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_READ_ALL: begin
						if (sts.empty) begin
							ctl.set_res = 1'b1;
							ctl.res     = ST_EMPTY;
							state_d     = S_EMIT;
						end else begin
							ctl.walk_init = 1'b1;
							ctl.rsel      = RA_HEAD;
							state_d       = S_RWALK;
						end
					end
					CMD_INS_FRONT, CMD_INS_BACK: begin
						if (sts.full) begin
							ctl.set_res = 1'b1;
							ctl.res     = ST_FULL;
							state_d     = S_EMIT;
						end else begin
							ctl.rsel = RA_FREE;
							state_d  = S_INS;
						end
					end
					CMD_INS_AFTER: begin
						if (sts.full || sts.empty) begin
							ctl.set_res = 1'b1;
							ctl.res     = sts.full ? ST_FULL : ST_EMPTY;
							state_d     = S_EMIT;
						end else begin
							ctl.walk_init = 1'b1;
							ctl.rsel      = RA_HEAD;
							state_d       = S_SRCH;
						end
					end
					CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_KEY: begin
						if (sts.empty) begin
							ctl.set_res = 1'b1;
							ctl.res     = ST_EMPTY;
							state_d     = S_EMIT;
						end else begin
							ctl.walk_init = 1'b1;
							ctl.rsel      = RA_HEAD;
							if (sts.cmd == CMD_DEL_KEY) begin
								state_d = S_SRCH;
							end else if (sts.cmd == CMD_DEL_FRONT || sts.one) begin
								ctl.head_del = 1'b1;
								state_d      = S_DROP;
							end else begin
								ctl.minus2 = 1'b1;
								state_d    = S_BWALK;
							end
						end
					end
					default: begin
						ctl.set_res = 1'b1;
						ctl.res     = ST_OK;
						state_d     = S_EMIT;
					end
				endcase
			end
			S_RWALK: begin
				if (sts.out_free) begin
					ctl.emit_walk = 1'b1;
					ctl.step      = 1'b1;
					ctl.rsel      = RA_LINK;
					if (sts.rem_zero) begin
						state_d = S_IDLE;
					end
				end
			end
			S_SRCH: begin
				if (sts.match) begin
					ctl.found = 1'b1;
					state_d   = (sts.cmd == CMD_INS_AFTER) ? S_ADD : S_DROP;
				end else if (sts.rem_zero) begin
					ctl.set_res = 1'b1;
					ctl.res     = ST_NOT_FOUND;
					state_d     = S_EMIT;
				end else begin
					ctl.step = 1'b1;
					ctl.rsel = RA_LINK;
				end
			end
			S_BWALK: begin
				if (sts.rem_zero) begin
					ctl.to_tail = 1'b1;
					ctl.rsel    = RA_TAIL;
					state_d     = S_DROP;
				end else begin
					ctl.step = 1'b1;
					ctl.rsel = RA_LINK;
				end
			end
			S_INS: begin
				ctl.ins     = 1'b1;
				ctl.set_res = 1'b1;
				state_d     = S_EMIT;
			end
			S_ADD: begin
				ctl.add  = 1'b1;
				ctl.rsel = RA_FREE;
				state_d  = S_ADD2;
			end
			S_ADD2: begin
				ctl.add2    = 1'b1;
				ctl.set_res = 1'b1;
				state_d     = S_EMIT;
			end
			S_DROP: begin
				ctl.drop = 1'b1;
				state_d  = S_DFREE;
			end
			S_DFREE: begin
				ctl.dfree = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/cle_dpath.sv =====
// Datapath of the circular list engine: list pointers, value and link stores,
// walk registers and the result register. Depends on cle_pkg, cle_if and cle_ram.
`timescale 1ns / 1ps
module cle_dpath #(
	parameter int LIST_DEPTH  = cle_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_WIDTH = cle_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         in_cmd,
	input  logic signed [31:0] in_item,
	input  logic signed [31:0] in_key,
	cle_out_if.source          res_chan,
	input  cle_pkg::cle_cmd_t  ctl,
	output cle_pkg::cle_sts_t  sts
);
	import cle_pkg::*;

	localparam int IW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int VW = VALUE_WIDTH;

	logic [2:0]      cmd_q;
	logic [VW-1:0]   item_q, key_q;
	logic [IW-1:0]   head_q, tail_q, free_q, cur_q, prev_q, nxt_q, raddr_s1;
	logic [CW-1:0]   count_q, rem_q;
	logic            first_q, at_head_q;
	logic [LIST_DEPTH-1:0] lvalid_q;
	status_t         res_status_q;
	logic [31:0]     res_value_q;
	logic            out_valid_q, out_last_q;
	status_t         out_status_q;
	logic [31:0]     out_value_q;
	logic [5:0]      out_count_q;

	logic [IW-1:0]   rd_addr, lram_rd, link_rd, lw_addr, lw_data, lseq;
	logic [VW-1:0]   vram_rd;
	logic            lw_en, vw_en, empty;
	logic [31:0]     val_out;

	always_comb begin
		case (ctl.rsel)
			RA_HEAD: rd_addr = head_q;
			RA_FREE: rd_addr = free_q;
			RA_TAIL: rd_addr = tail_q;
			RA_LINK: rd_addr = link_rd;
			default: rd_addr = cur_q;
		endcase
	end

	assign lseq    = (raddr_s1 == IW'(LIST_DEPTH - 1)) ? '0 : raddr_s1 + 1'b1;
	assign link_rd = lvalid_q[raddr_s1] ? lram_rd : lseq;
	assign val_out = 32'(vram_rd);
	assign empty   = (count_q == '0);

	assign sts.cmd      = cmd_q;
	assign sts.empty    = empty;
	assign sts.full     = (count_q == CW'(LIST_DEPTH));
	assign sts.one      = (count_q == CW'(1));
	assign sts.match    = (vram_rd == key_q);
	assign sts.rem_zero = (rem_q == '0);
	assign sts.out_free = !out_valid_q || res_chan.ready;

	always_comb begin
		lw_en   = 1'b0;
		lw_addr = cur_q;
		lw_data = free_q;
		if (ctl.ins && !empty) begin
			lw_en = 1'b1;
			if (cmd_q == CMD_INS_FRONT) begin
				lw_addr = free_q;
				lw_data = head_q;
			end else begin
				lw_addr = tail_q;
				lw_data = free_q;
			end
		end
		if (ctl.add) begin
			lw_en   = 1'b1;
			lw_addr = cur_q;
			lw_data = free_q;
		end
		if (ctl.add2) begin
			lw_en   = 1'b1;
			lw_addr = free_q;
			lw_data = nxt_q;
		end
		if (ctl.drop && !at_head_q) begin
			lw_en   = 1'b1;
			lw_addr = prev_q;
			lw_data = link_rd;
		end
		if (ctl.dfree) begin
			lw_en   = 1'b1;
			lw_addr = cur_q;
			lw_data = free_q;
		end
	end

	assign vw_en = ctl.ins || ctl.add2;

	cle_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (vw_en),
		.waddr (free_q),
		.wdata (item_q),
		.raddr (rd_addr),
		.rdata (vram_rd)
	);

	cle_ram #(.WIDTH(IW), .DEPTH(LIST_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lw_en),
		.waddr (lw_addr),
		.wdata (lw_data),
		.raddr (rd_addr),
		.rdata (lram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			count_q     <= '0;
			lvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (lw_en) begin
				lvalid_q[lw_addr] <= 1'b1;
			end
			if (ctl.ins) begin
				free_q  <= link_rd;
				count_q <= count_q + 1'b1;
				if (empty) begin
					head_q <= free_q;
					tail_q <= free_q;
				end else if (cmd_q == CMD_INS_FRONT) begin
					head_q <= free_q;
				end else begin
					tail_q <= free_q;
				end
			end
			if (ctl.add2) begin
				free_q  <= link_rd;
				count_q <= count_q + 1'b1;
				if (cur_q == tail_q) begin
					tail_q <= free_q;
				end
			end
			if (ctl.drop) begin
				count_q <= count_q - 1'b1;
				if (at_head_q) begin
					head_q <= link_rd;
				end else if (cur_q == tail_q) begin
					tail_q <= prev_q;
				end
			end
			if (ctl.dfree) begin
				free_q <= cur_q;
				if (empty) begin
					tail_q <= head_q;
				end
			end
			if (ctl.emit_walk || ctl.emit_res) begin
				out_valid_q <= 1'b1;
			end else if (res_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= rd_addr;
		if (ctl.latch) begin
			cmd_q  <= in_cmd;
			item_q <= VW'(in_item);
			key_q  <= VW'(in_key);
		end
		if (ctl.walk_init) begin
			cur_q   <= head_q;
			prev_q  <= head_q;
			first_q <= 1'b1;
			rem_q   <= ctl.minus2 ? CW'(count_q - CW'(2)) : CW'(count_q - CW'(1));
		end
		if (ctl.step) begin
			cur_q   <= link_rd;
			prev_q  <= cur_q;
			rem_q   <= rem_q - 1'b1;
			first_q <= 1'b0;
		end
		if (ctl.to_tail) begin
			prev_q    <= cur_q;
			cur_q     <= tail_q;
			at_head_q <= 1'b0;
		end
		if (ctl.head_del) begin
			at_head_q <= 1'b1;
		end
		if (ctl.found) begin
			at_head_q <= first_q;
		end
		if (ctl.add) begin
			nxt_q <= link_rd;
		end
		if (ctl.set_res) begin
			res_status_q <= ctl.res;
			res_value_q  <= '0;
		end
		if (ctl.drop) begin
			res_status_q <= ST_OK;
			res_value_q  <= val_out;
		end
		if (ctl.emit_walk) begin
			out_status_q <= ST_OK;
			out_value_q  <= val_out;
			out_last_q   <= (rem_q == '0);
			out_count_q  <= 6'(count_q);
		end
		if (ctl.emit_res) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_last_q   <= 1'b1;
			out_count_q  <= 6'(count_q);
		end
	end

	assign res_chan.valid       = out_valid_q;
	assign res_chan.status      = out_status_q;
	assign res_chan.entry_value = out_value_q;
	assign res_chan.last        = out_last_q;
	assign res_chan.entry_count = out_count_q;
endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checker for the circular list engine, bound to the top level.
// Depends on cle_pkg and circular_list_engine.
`timescale 1ns / 1ps
module cle_checker #(
	parameter int LIST_DEPTH = cle_pkg::LIST_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_value,
	input logic        out_last,
	input logic [5:0]  out_count
);
	import cle_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result withdrawn before transfer.");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Command taken while another is in work.");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_last)
		else $error("Error result without last mark.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_EMPTY |-> out_value == '0 && out_count == '0)
		else $error("Empty status with data or entries.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> out_count == 6'(LIST_DEPTH))
		else $error("Full status with wrong entry count.");
endmodule

bind circular_list_engine cle_checker #(.LIST_DEPTH(LIST_DEPTH)) u_cle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd_chan.valid),
	.in_ready   (cmd_chan.ready),
	.out_valid  (res_chan.valid),
	.out_ready  (res_chan.ready),
	.out_status (res_chan.status),
	.out_value  (res_chan.entry_value),
	.out_last   (res_chan.last),
	.out_count  (res_chan.entry_count)
);
